// ----- rtl/multi_pattern_byte_search_unit_defines.svh -----
// Assertion macros shared by the checkers of the byte search unit.
`ifndef MULTI_PATTERN_BYTE_SEARCH_UNIT_DEFINES_SVH
`define MULTI_PATTERN_BYTE_SEARCH_UNIT_DEFINES_SVH

// The consequent must hold in the clock after the antecedent.
`define MPBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte search check failed: next-cycle property");

// The consequent must hold in the same clock as the antecedent.
`define MPBS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte search check failed: same-cycle property");

`endif

// ----- rtl/mpbs_pkg.sv -----
package mpbs_pkg;

   localparam int NumPatterns   = 4;
   localparam int MaxPatternLen = 8;
   localparam int OffsetBits    = 48;
   localparam int LenBits       = 4;
   localparam int IdxBits       = 2;
   localparam int FillBits      = 4;
   localparam int PatternBits   = 64;
   localparam int CsrIndexBits  = 3;
   localparam int CsrDataBits   = 64;
   localparam int ReqDataBits   = 8;
   localparam int RspDataBits   = 56;
   localparam int RspPadBits    = RspDataBits - OffsetBits - IdxBits;
   localparam int QueueDepth    = 4;
   localparam int QPtrBits      = 2;
   localparam int QCountBits    = 3;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_A = 3'd0,
      CSR_PATTERN_B = 3'd1,
      CSR_PATTERN_C = 3'd2,
      CSR_PATTERN_D = 3'd3,
      CSR_LENGTH_A  = 3'd4,
      CSR_LENGTH_B  = 3'd5,
      CSR_LENGTH_C  = 3'd6,
      CSR_LENGTH_D  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [NumPatterns-1:0][PatternBits-1:0] pattern;
      logic [NumPatterns-1:0][LenBits-1:0]     length;
   } csr_type;

   // One queue entry: the patterns that hit on a byte and that byte's offset.
   typedef struct packed {
      logic [NumPatterns-1:0] hits;
      logic [OffsetBits-1:0]  here;
   } qent_type;

   // Lengths above the longest supported pattern count as the longest.
   function automatic logic [LenBits-1:0] clamp_len(input logic [LenBits-1:0] len);
      logic [LenBits-1:0] res;
      res = (len > LenBits'(MaxPatternLen)) ? LenBits'(MaxPatternLen) : len;
      return res;
   endfunction

endpackage

// ----- rtl/mpbs_front.sv -----
module mpbs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mpbs_pkg::ReqDataBits-1:0]    req_tdata,
   input  logic [0:0]                          req_tuser,
   input  mpbs_pkg::csr_type                   csr,
   input  logic                                q_full,
   output logic                                push_valid,
   output mpbs_pkg::qent_type                  push_entry
);

   logic [mpbs_pkg::MaxPatternLen-1:0][7:0]               hist_ff, hist_in, hist_base;
   logic [mpbs_pkg::OffsetBits-1:0]                       count_ff, count_in, count_base;
   logic [mpbs_pkg::NumPatterns-1:0][mpbs_pkg::LenBits-1:0] skip_ff, skip_in, skip_base;
   logic [mpbs_pkg::FillBits-1:0]                         fill_ff, fill_in, fill_base;
   logic [mpbs_pkg::NumPatterns-1:0]                      hit;
   logic                                                  accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic [mpbs_pkg::LenBits-1:0] len;
      logic [mpbs_pkg::LenBits-1:0] pos;
      logic                         match;
      logic [mpbs_pkg::MaxPatternLen-1:0][7:0] hist_new;
      logic [mpbs_pkg::FillBits-1:0] fill_new;

      // A restart clears the history before the incoming byte is taken.
      hist_base  = req_tuser[0] ? '0 : hist_ff;
      count_base = req_tuser[0] ? '0 : count_ff;
      skip_base  = req_tuser[0] ? '0 : skip_ff;
      fill_base  = req_tuser[0] ? '0 : fill_ff;

      hist_new[0] = req_tdata[7:0];
      for (int i = 1; i < mpbs_pkg::MaxPatternLen; i++) begin
         hist_new[i] = hist_base[i-1];
      end
      fill_new = (fill_base < mpbs_pkg::FillBits'(mpbs_pkg::MaxPatternLen)) ?
                 fill_base + 1'b1 : fill_base;

      for (int p = 0; p < mpbs_pkg::NumPatterns; p++) begin
         len   = mpbs_pkg::clamp_len(csr.length[p]);
         match = 1'b1;
         for (int k = 0; k < mpbs_pkg::MaxPatternLen; k++) begin
            pos = len - 1'b1 - mpbs_pkg::LenBits'(k);
            if (mpbs_pkg::LenBits'(k) < len &&
                hist_new[pos[2:0]] != csr.pattern[p][8*k +: 8]) begin
               match = 1'b0;
            end
         end
         hit[p] = (len != '0) && (skip_base[p] == '0) && (fill_new >= len) && match;
         if (len == '0) begin
            skip_in[p] = skip_base[p];
         end else if (skip_base[p] != '0) begin
            skip_in[p] = skip_base[p] - 1'b1;
         end else if (hit[p]) begin
            skip_in[p] = len - 1'b1;
         end else begin
            skip_in[p] = skip_base[p];
         end
      end

      hist_in  = hist_new;
      fill_in  = fill_new;
      count_in = count_base + 1'b1;
   end

   assign push_valid      = accept && (hit != '0);
   assign push_entry.hits = hit;
   assign push_entry.here = count_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         count_ff <= '0;
         skip_ff  <= '0;
         fill_ff  <= '0;
      end else if (accept) begin
         hist_ff  <= hist_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

// ----- rtl/mpbs_queue.sv -----
module mpbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  mpbs_pkg::qent_type  push_entry,
   output logic                q_full,
   output logic                q_valid,
   output mpbs_pkg::qent_type  q_entry,
   input  logic                pop
);

   mpbs_pkg::qent_type                  mem_ff [mpbs_pkg::QueueDepth];
   logic [mpbs_pkg::QPtrBits-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mpbs_pkg::QPtrBits-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mpbs_pkg::QCountBits-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign q_full  = (count_ff == mpbs_pkg::QCountBits'(mpbs_pkg::QueueDepth));
   assign q_valid = (count_ff != '0);
   assign q_entry = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/mpbs_back.sv -----
module mpbs_back (
   input  logic                               clock,
   input  logic                               reset,
   input  mpbs_pkg::csr_type                  csr,
   input  logic                               q_valid,
   input  mpbs_pkg::qent_type                 q_entry,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mpbs_pkg::RspDataBits-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);

   logic                                   cur_valid_ff, cur_valid_in;
   logic [mpbs_pkg::NumPatterns-1:0]       cur_mask_ff, cur_mask_in;
   logic [mpbs_pkg::OffsetBits-1:0]        cur_here_ff, cur_here_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [mpbs_pkg::IdxBits-1:0]           out_idx_ff, out_idx_in;
   logic [mpbs_pkg::OffsetBits-1:0]        out_offset_ff, out_offset_in;
   logic                                   out_last_ff, out_last_in;
   logic [mpbs_pkg::IdxBits-1:0]           sel;
   logic [mpbs_pkg::NumPatterns-1:0]       remaining;
   logic                                   last;
   logic                                   can_emit;
   logic [mpbs_pkg::LenBits-1:0]           sel_len;

   // Lowest pending pattern first, so hits leave in ascending order.
   always_comb begin
      sel = '0;
      for (int p = mpbs_pkg::NumPatterns - 1; p >= 0; p--) begin
         if (cur_mask_ff[p]) begin
            sel = mpbs_pkg::IdxBits'(p);
         end
      end
   end

   always_comb begin
      remaining      = cur_mask_ff;
      remaining[sel] = 1'b0;
   end

   assign last     = (remaining == '0);
   assign can_emit = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign pop      = q_valid && (!cur_valid_ff || (can_emit && last));
   assign sel_len  = mpbs_pkg::clamp_len(csr.length[sel]);

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_mask_in   = cur_mask_ff;
      cur_here_in   = cur_here_ff;
      out_valid_in  = out_valid_ff;
      out_idx_in    = out_idx_ff;
      out_offset_in = out_offset_ff;
      out_last_in   = out_last_ff;

      if (pop) begin
         cur_valid_in = 1'b1;
         cur_mask_in  = q_entry.hits;
         cur_here_in  = q_entry.here;
      end else if (can_emit) begin
         cur_valid_in = !last;
         cur_mask_in  = remaining;
      end

      if (can_emit) begin
         out_valid_in  = 1'b1;
         out_idx_in    = sel;
         // The match starts length-1 bytes before the byte that completed it.
         out_offset_in = cur_here_ff - mpbs_pkg::OffsetBits'(sel_len - 1'b1);
         out_last_in   = last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_mask_ff   <= cur_mask_in;
      cur_here_ff   <= cur_here_in;
      out_idx_ff    <= out_idx_in;
      out_offset_ff <= out_offset_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{mpbs_pkg::RspPadBits{1'b0}}, out_offset_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- rtl/multi_pattern_byte_search_unit.sv -----
// Multi-pattern byte search. The unit scans a byte stream against up to four
// byte patterns of up to eight bytes each and reports, for every pattern on
// its own, each leftmost non-overlapping occurrence as one response carrying
// the pattern number and the stream offset of the first byte of the match.
// Hits caused by one byte come out in ascending pattern order, and the last of
// them has tlast set. A pattern of length zero is disabled; a restart flag on
// a request clears the history, the skip counters and the offset, and that
// byte gets offset zero. Offsets wrap at 48 bits. The front end takes one
// byte per clock cycle and evaluates all patterns in that cycle; bytes that
// hit are passed through a four-entry queue to the back end, which issues one
// response per cycle into a registered output stage unless that stage holds
// a response the receiver refuses, and requests stall only while the queue
// is full. A hit passes the queue, the current entry register and the output
// stage on its way to the response port. The user must write pattern and
// length registers through the csr port only while the unit is idle; the
// block does not enforce this, and there is no clearing pass after reset.
module multi_pattern_byte_search_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [mpbs_pkg::ReqDataBits-1:0]       req_tdata,   // [7:0] data_byte
   input  logic [0:0]                             req_tuser,   // [0] restart
   // Response channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [1:0] pattern_index, [49:2] match_offset, [55:50] zero
   output logic [mpbs_pkg::RspDataBits-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   // Register write port.
   input  logic                                   csr_we,
   input  logic [mpbs_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [mpbs_pkg::CsrDataBits-1:0]       csr_wdata
);

   mpbs_pkg::csr_type   csr_ff, csr_in;
   logic                push_valid;
   mpbs_pkg::qent_type  push_entry;
   logic                q_full;
   logic                q_valid;
   mpbs_pkg::qent_type  q_entry;
   logic                pop;

   // Register file: each write replaces one pattern or one length. Lengths
   // keep only their four low bits.
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (mpbs_pkg::csr_index_type'(csr_index))
            mpbs_pkg::CSR_PATTERN_A: begin
               csr_in.pattern[0] = csr_wdata;
            end
            mpbs_pkg::CSR_PATTERN_B: begin
               csr_in.pattern[1] = csr_wdata;
            end
            mpbs_pkg::CSR_PATTERN_C: begin
               csr_in.pattern[2] = csr_wdata;
            end
            mpbs_pkg::CSR_PATTERN_D: begin
               csr_in.pattern[3] = csr_wdata;
            end
            mpbs_pkg::CSR_LENGTH_A: begin
               csr_in.length[0] = csr_wdata[mpbs_pkg::LenBits-1:0];
            end
            mpbs_pkg::CSR_LENGTH_B: begin
               csr_in.length[1] = csr_wdata[mpbs_pkg::LenBits-1:0];
            end
            mpbs_pkg::CSR_LENGTH_C: begin
               csr_in.length[2] = csr_wdata[mpbs_pkg::LenBits-1:0];
            end
            mpbs_pkg::CSR_LENGTH_D: begin
               csr_in.length[3] = csr_wdata[mpbs_pkg::LenBits-1:0];
            end
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front end: history, offset and skip counters; finds the hits of a byte.
   mpbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr        (csr_ff),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Short queue of bytes that hit, so either side can stall on its own.
   mpbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop)
   );

   // Back end: splits a hit set into single responses.
   mpbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/mpbs_checker.sv -----
`include "multi_pattern_byte_search_unit_defines.svh"

module mpbs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [mpbs_pkg::RspDataBits-1:0]     rsp_tdata,
   input  logic                                 rsp_tlast
);

   // A stalled response stays offered.
   `MPBS_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // No response right after reset.
   `MPBS_ASSERT_NEXT(rsp_reset_chk, clock, 1'b0, reset, !rsp_tvalid)

   // The highest pattern number can only be the last hit of its byte.
   `MPBS_ASSERT_SAME(rsp_top_last_chk, clock, reset, rsp_tvalid && rsp_tdata[1:0] == mpbs_pkg::IdxBits'(mpbs_pkg::NumPatterns - 1), rsp_tlast)

   // Hits of one byte leave in strictly ascending pattern order.
   `MPBS_ASSERT_NEXT(rsp_order_chk, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !rsp_tvalid || rsp_tdata[1:0] > $past(rsp_tdata[1:0]))

endmodule

bind multi_pattern_byte_search_unit mpbs_checker u_checker (.*);

// ----- sim/byte_search_hit_checker.sv -----
`timescale 1ns / 100ps

// Watches the register port and both streams of the byte search unit. It keeps
// its own copy of the search state, predicts the hits of every accepted
// request and compares each response with the oldest hit still due.
module byte_search_hit_checker
   import mpbs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataBits-1:0]  req_tdata,
   input  logic [0:0]              req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataBits-1:0]  rsp_tdata,
   input  logic                    rsp_tlast,
   input  logic                    csr_we,
   input  csr_index_type           csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata,
   output int                      outstanding,
   output int                      mismatch_count
);

   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [IdxBits-1:0]    pattern_no;
      logic [OffsetBits-1:0] start;
      logic                  is_last;
   } search_hit_t;

   logic [PatternBits-1:0] pattern_reg [NumPatterns];
   logic [LenBits-1:0]     length_reg [NumPatterns];
   logic [LenBits-1:0]     skip_count [NumPatterns];
   logic [7:0]             history [MaxPatternLen];
   logic [OffsetBits-1:0]  next_offset;
   int                     fill;
   int                     errors;
   search_hit_t            hits_due [$];

   // Shifts one byte into the history and queues the hits that it completes.
   task automatic scan_byte(input logic [7:0] value, input logic restart);
      search_hit_t           found [NumPatterns];
      int                    n;
      int                    len;
      logic                  match;
      logic [OffsetBits-1:0] here;
      n = 0;
      if (restart) begin
         for (int i = 0; i < MaxPatternLen; i++) history[i] = '0;
         for (int p = 0; p < NumPatterns; p++) skip_count[p] = '0;
         next_offset = '0;
         fill = 0;
      end
      here = next_offset;
      for (int i = MaxPatternLen - 1; i > 0; i--) history[i] = history[i - 1];
      history[0] = value;
      if (fill < MaxPatternLen) fill++;
      for (int p = 0; p < NumPatterns; p++) begin
         len = (length_reg[p] > MaxPatternLen) ? MaxPatternLen : int'(length_reg[p]);
         if (len != 0) begin
            if (skip_count[p] != 0) begin
               skip_count[p] = skip_count[p] - 1'b1;
            end else if (fill >= len) begin
               match = 1'b1;
               for (int k = 0; k < len; k++)
                  if (history[len - 1 - k] != pattern_reg[p][8*k +: 8]) match = 1'b0;
               if (match) begin
                  found[n].pattern_no = IdxBits'(p);
                  found[n].start      = here - OffsetBits'(len - 1);
                  found[n].is_last    = 1'b0;
                  n++;
                  skip_count[p] = LenBits'(len - 1);
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         found[i].is_last = (i == n - 1);
         hits_due = {hits_due, found[i]};
      end
      next_offset = next_offset + 1'b1;
   endtask

   task automatic check_response();
      search_hit_t           want;
      logic [IdxBits-1:0]    got_no;
      logic [OffsetBits-1:0] got_start;
      logic [RspPadBits-1:0] got_pad;
      got_no    = rsp_tdata[IdxBits-1:0];
      got_start = rsp_tdata[IdxBits +: OffsetBits];
      got_pad   = rsp_tdata[RspDataBits-1 -: RspPadBits];
      if (hits_due.size() == 0) begin
         errors++;
         if (errors <= ReportLimit)
            $display("%0t: hit with none due: pattern %0d offset %0d last %0b",
                     $realtime, got_no, got_start, rsp_tlast);
      end else begin
         want = hits_due.pop_front();
         if (got_no !== want.pattern_no || got_start !== want.start ||
             rsp_tlast !== want.is_last || got_pad !== '0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: hit mismatch: expected pattern %0d offset %0d last %0b, got pattern %0d offset %0d last %0b pad %h",
                        $realtime, want.pattern_no, want.start, want.is_last,
                        got_no, got_start, rsp_tlast, got_pad);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NumPatterns; p++) begin
            pattern_reg[p] = '0;
            length_reg[p]  = '0;
            skip_count[p]  = '0;
         end
         for (int i = 0; i < MaxPatternLen; i++) history[i] = '0;
         next_offset = '0;
         fill = 0;
         hits_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_A: pattern_reg[0] = csr_wdata;
               CSR_PATTERN_B: pattern_reg[1] = csr_wdata;
               CSR_PATTERN_C: pattern_reg[2] = csr_wdata;
               CSR_PATTERN_D: pattern_reg[3] = csr_wdata;
               CSR_LENGTH_A:  length_reg[0]  = csr_wdata[LenBits-1:0];
               CSR_LENGTH_B:  length_reg[1]  = csr_wdata[LenBits-1:0];
               CSR_LENGTH_C:  length_reg[2]  = csr_wdata[LenBits-1:0];
               CSR_LENGTH_D:  length_reg[3]  = csr_wdata[LenBits-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata[7:0], req_tuser[0]);
         if (rsp_tvalid && rsp_tready) check_response();
      end
      outstanding    <= hits_due.size();
      mismatch_count <= errors;
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import mpbs_pkg::*;

   // Bound on the whole run.
   localparam int CycleLimit = 400000;
   // Wait allowed for the unit to settle once no hit is due any more, enough
   // for the pipeline registers plus a full four-entry hit queue, with margin.
   localparam int SettleCycles = 12;
   // Number of random requests in each configuration phase.
   localparam int PhaseRequests = 65;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataBits-1:0]  req_tdata = '0;
   logic [0:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   csr_index_type           csr_index = CSR_PATTERN_A;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   int outstanding;
   int mismatch_count;
   int cycle_count = 0;

   // Chance, in percent, that the sender holds back a request or the receiver
   // refuses a response in a given cycle.
   int send_idle_pct = 11;
   int recv_idle_pct = 83;

   // The settings currently loaded, kept here only to shape the stimulus: the
   // raw length as written (it may exceed the longest pattern) and the bytes.
   logic [PatternBits-1:0] pat_sel [NumPatterns];
   logic [LenBits-1:0]     len_raw [NumPatterns];
   // A small alphabet for each phase, so that random bytes hit often.
   logic [7:0]             symbols [3];

   multi_pattern_byte_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   byte_search_hit_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides afresh every cycle whether it takes a response. The
   // percentage is changed with nonblocking writes so that this block never
   // races with the stimulus process.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Presents one byte and holds it until the unit accepts it. Idle cycles are
   // inserted beforehand at random. On return the byte has just been taken,
   // and the valid line is still high so that the next request can follow
   // without a gap.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops sending and waits until every predicted hit has come back, then
   // lets the pipeline settle. The registers may only be written after this.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes all eight registers from the local copy. The length words carry
   // random upper bits, which the unit must ignore.
   task automatic load_registers();
      logic [CsrDataBits-1:0] word;
      for (int p = 0; p < NumPatterns; p++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(CSR_PATTERN_A + p);
         csr_wdata <= pat_sel[p];
         @(posedge clock);
      end
      for (int p = 0; p < NumPatterns; p++) begin
         word = {$urandom, $urandom};
         word[LenBits-1:0] = len_raw[p];
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(CSR_LENGTH_A + p);
         csr_wdata <= word;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Chooses a new setting. Mode 0 mixes all lengths, including disabled and
   // oversized ones. Mode 1 uses very short patterns built from one symbol,
   // so that several patterns hit on the same byte. Mode 2 sets the extremes:
   // disabled, exactly eight bytes, oversized and a single byte.
   task automatic program_search(input int mode);
      int r;
      int len;
      for (int s = 0; s < 3; s++) symbols[s] = 8'($urandom);
      for (int p = 0; p < NumPatterns; p++) begin
         case (mode)
            0: begin
               r = $urandom_range(99);
               if (r < 10)
                  len = 0;
               else if (r < 20)
                  len = $urandom_range(15, MaxPatternLen + 1);
               else
                  len = $urandom_range(MaxPatternLen, 1);
            end
            1: len = $urandom_range(2, 1);
            default: begin
               case (p)
                  0: len = 0;
                  1: len = MaxPatternLen;
                  2: len = 15;
                  default: len = 1;
               endcase
            end
         endcase
         len_raw[p] = LenBits'(len);
         // Bytes beyond the length stay random; they must not take part.
         pat_sel[p] = {$urandom, $urandom};
         if (len > MaxPatternLen) len = MaxPatternLen;
         for (int k = 0; k < len; k++)
            pat_sel[p][8*k +: 8] = (mode == 1) ? symbols[0] : symbols[$urandom_range(2)];
      end
      load_registers();
   endtask

   // Random stream. Most of it is whole copies of a loaded pattern, now and
   // then with one byte spoilt, mixed with bytes of the phase's alphabet and
   // with fully random bytes. A restart is raised on about one request in
   // fifty.
   task automatic scan_random(input int count);
      int         sent;
      int         r;
      int         p;
      int         len;
      logic [7:0] value;
      sent = 0;
      while (sent < count) begin
         r   = $urandom_range(99);
         p   = $urandom_range(NumPatterns - 1);
         len = (len_raw[p] > MaxPatternLen) ? MaxPatternLen : int'(len_raw[p]);
         if (r < 45 && len != 0) begin
            for (int k = 0; k < len && sent < count; k++) begin
               value = pat_sel[p][8*k +: 8];
               if ($urandom_range(99) < 5) value = 8'($urandom);
               send_byte(value, $urandom_range(99) < 2);
               sent++;
            end
         end else begin
            if (r < 85)
               value = symbols[$urandom_range(2)];
            else
               value = 8'($urandom);
            send_byte(value, $urandom_range(99) < 2);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Pattern 0 is two equal bytes, so a run of four of them
      // shows that hits do not overlap. Pattern 1 is two zero bytes, which
      // the cleared history must not complete early. Pattern 2 is eight bytes
      // of all ones with an oversized length, which must count as eight.
      // Pattern 3 is disabled although its first byte would match.
      pat_sel[0] = {$urandom, $urandom};
      pat_sel[0][15:0] = 16'h6161;
      len_raw[0] = 4'd2;
      pat_sel[1] = {$urandom, $urandom};
      pat_sel[1][15:0] = 16'h0000;
      len_raw[1] = 4'd2;
      pat_sel[2] = '1;
      len_raw[2] = 4'd15;
      pat_sel[3] = {$urandom, $urandom};
      pat_sel[3][7:0] = 8'h61;
      len_raw[3] = 4'd0;
      load_registers();

      // A single zero after a restart is too short a history for pattern 1;
      // then it hits at offsets 0 and 2 only.
      send_byte(8'h00, 1'b1);
      repeat (3) send_byte(8'h00, 1'b0);
      // Pattern 0 hits at offsets 4 and 6.
      repeat (4) send_byte(8'h61, 1'b0);
      // Pattern 2 hits once at offset 8; the ninth byte falls in its skip.
      repeat (9) send_byte(8'hFF, 1'b0);
      // A restart in mid-stream: the offset starts again at zero.
      send_byte(8'h61, 1'b1);
      send_byte(8'h61, 1'b0);
      repeat (2) send_byte(8'h00, 1'b0);
      drain();

      // Random phases. The sender is mostly busy and the receiver mostly
      // stalled at first, then the other way round, then neither idles.
      // No restart is forced between phases, so a skip left over from the
      // old lengths runs down under the new ones.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle_pct = 83;
            recv_idle_pct <= 11;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         program_search(ph % 3);
         scan_random(PhaseRequests);
         drain();
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
